// ===== rtl/core/psgseq_pkg.sv =====
package psgseq_pkg;

  // Function codes carried in the func field.
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_PLAY = 2'd1;
  localparam logic [1:0] FUNC_INIT = 2'd2;

  // Effect numbers.
  localparam logic [3:0] EFF_NONE        = 4'd0;
  localparam logic [3:0] EFF_LASER       = 4'd1;
  localparam logic [3:0] EFF_FOOTSTEP    = 4'd2;
  localparam logic [3:0] EFF_ROLL        = 4'd3;
  localparam logic [3:0] EFF_PICKUP      = 4'd4;
  localparam logic [3:0] EFF_DAMAGE      = 4'd5;
  localparam logic [3:0] EFF_MENU_MOVE   = 4'd6;
  localparam logic [3:0] EFF_MENU_SELECT = 4'd7;
  localparam logic [3:0] EFF_SWITCH      = 4'd8;

  // Sound chip command bytes.
  localparam logic [7:0] CMD_TONE0_DIV  = 8'h80;
  localparam logic [7:0] CMD_TONE0_ATT  = 8'h90;
  localparam logic [7:0] CMD_NOISE_CTRL = 8'hE0;
  localparam logic [7:0] CMD_NOISE_ATT  = 8'hF0;
  localparam logic [7:0] CMD_MUTE_CH0   = 8'h9F;
  localparam logic [7:0] CMD_MUTE_CH1   = 8'hBF;
  localparam logic [7:0] CMD_MUTE_CH2   = 8'hDF;
  localparam logic [7:0] CMD_MUTE_NOISE = 8'hFF;

  localparam int unsigned MAX_BYTES = 4;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] sfx_id;
  } in_t;

  typedef struct packed {
    logic [7:0] port_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic [3:0] effect;
    logic [3:0] tick;
  } seq_state_t;

  // Command bytes produced for one input item, first byte in entry 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
  } burst_t;

endpackage

// ===== rtl/core/psgseq_gen.sv =====
module psgseq_gen (
  input  psgseq_pkg::in_t        item,
  input  psgseq_pkg::seq_state_t st,
  output psgseq_pkg::seq_state_t st_nxt,
  output psgseq_pkg::burst_t     burst
);

  logic        tone;
  logic        noise;
  logic        mute;
  logic [10:0] div;
  logic [3:0]  att;
  logic [2:0]  ctrl;
  logic [3:0]  t;

  always_comb begin
    st_nxt = st;
    tone   = 1'b0;
    noise  = 1'b0;
    mute   = 1'b0;
    div    = '0;
    att    = '0;
    ctrl   = '0;
    t      = st.tick + 4'd1;
    burst  = '0;

    unique case (item.func)
      psgseq_pkg::FUNC_TICK: begin
        if (st.effect != psgseq_pkg::EFF_NONE) begin
          st_nxt.tick = t;
          unique case (st.effect)
            psgseq_pkg::EFF_LASER: begin
              if (t < 4'd6) begin
                tone = 1'b1;
                div  = 11'd200 + 11'(t) * 11'd100;
                att  = {t[2:0], 1'b0};
              end
            end
            psgseq_pkg::EFF_FOOTSTEP: begin
              if (t == 4'd1) begin
                noise = 1'b1;
                ctrl  = 3'd6;
                att   = 4'd9;
              end
            end
            psgseq_pkg::EFF_ROLL: begin
              if (t < 4'd8) begin
                tone = 1'b1;
                div  = 11'd500 - 11'(t) * 11'd40;
                att  = t + 4'd3;
              end
            end
            psgseq_pkg::EFF_PICKUP: begin
              if (t < 4'd5) begin
                tone = 1'b1;
                div  = 11'd180;
                att  = 4'd1;
              end else if (t < 4'd10) begin
                tone = 1'b1;
                div  = 11'd120;
                att  = 4'd0;
              end
            end
            psgseq_pkg::EFF_DAMAGE: begin
              if (t < 4'd8) begin
                noise = 1'b1;
                ctrl  = 3'd7;
                att   = t;
              end
            end
            psgseq_pkg::EFF_MENU_MOVE: begin
              if (t < 4'd3) begin
                tone = 1'b1;
                div  = 11'd250;
                att  = 4'd3;
              end
            end
            psgseq_pkg::EFF_MENU_SELECT: begin
              if (t < 4'd4) begin
                tone = 1'b1;
                div  = 11'd180;
                att  = 4'd1;
              end else if (t < 4'd8) begin
                tone = 1'b1;
                div  = 11'd100;
                att  = 4'd0;
              end
            end
            psgseq_pkg::EFF_SWITCH: begin
              if (t < 4'd6) begin
                tone = 1'b1;
                div  = 11'd350 + 11'(t) * 11'd40;
                att  = 4'd3;
              end
            end
            default: begin
            end
          endcase
          // A finished or unknown effect silences everything and stops.
          if (!tone && !noise) begin
            mute          = 1'b1;
            st_nxt.effect = psgseq_pkg::EFF_NONE;
          end
        end
      end
      psgseq_pkg::FUNC_PLAY: begin
        st_nxt.effect = item.sfx_id;
        st_nxt.tick   = 4'd0;
      end
      psgseq_pkg::FUNC_INIT: begin
        st_nxt.effect = psgseq_pkg::EFF_NONE;
        st_nxt.tick   = 4'd0;
        mute          = 1'b1;
      end
      default: begin
      end
    endcase

    if (tone) begin
      burst.bytes[0] = psgseq_pkg::CMD_TONE0_DIV | {4'b0000, div[3:0]};
      burst.bytes[1] = {2'b00, div[9:4]};
      burst.bytes[2] = psgseq_pkg::CMD_TONE0_ATT | {4'b0000, att};
      burst.count    = 3'd3;
    end else if (noise) begin
      burst.bytes[0] = psgseq_pkg::CMD_NOISE_CTRL | {5'b00000, ctrl};
      burst.bytes[1] = psgseq_pkg::CMD_NOISE_ATT | {4'b0000, att};
      burst.count    = 3'd2;
    end else if (mute) begin
      burst.bytes[0] = psgseq_pkg::CMD_MUTE_CH0;
      burst.bytes[1] = psgseq_pkg::CMD_MUTE_CH1;
      burst.bytes[2] = psgseq_pkg::CMD_MUTE_CH2;
      burst.bytes[3] = psgseq_pkg::CMD_MUTE_NOISE;
      burst.count    = 3'd4;
    end
  end

endmodule

// ===== rtl/core/sound_effect_psg_sequencer_top.sv =====
// Sound-effect sequencer for a four-channel sound chip.
// The input channel (in_valid, in_ready, in_data) takes one command per
// transfer: a frame tick, a play request or an init. The result channel
// (out_valid, out_ready, out_data) delivers the chip command bytes one per
// transfer, with last_byte set on the final byte that a command causes.
// A tone write gives three bytes, a noise write two and a mute four; play
// requests, ticks with no active effect and unused function codes give none.
// A command that gives bytes sits in the input register until the burst
// register is free, and is loaded into it; its first byte is then on
// the output, which reads straight from the burst register.
// Throughput: the output drains one byte per cycle while the receiver is
// ready, and a burst holds at most four bytes; commands that give no bytes
// pass at one per cycle even while a burst is draining.
// The input register takes a new command while a burst still waits, so the
// sender is stalled only when both the input register and burst are full.
// When the receiver stalls, the current byte is held and the pipeline fills.
// Synchronous reset clears the effect, the frame count and all valid flags.
module sound_effect_psg_sequencer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psgseq_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output psgseq_pkg::out_t  out_data
);

  // Input register.
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  psgseq_pkg::in_t        s1_data_r;

  // Sequencer state, updated when a command leaves the input register.
  psgseq_pkg::seq_state_t state_r;
  psgseq_pkg::seq_state_t state_nxt;

  // Burst register feeding the output one byte at a time.
  logic                   buf_valid_r;
  logic                   buf_valid_nxt;
  logic [psgseq_pkg::MAX_BYTES-1:0][7:0] bytes_r;
  logic [2:0]             cnt_r;
  logic [1:0]             idx_r;
  logic [1:0]             idx_nxt;

  psgseq_pkg::burst_t     burst;
  logic                   buf_last;
  logic                   buf_free;
  logic                   s1_adv;
  logic                   load;

  psgseq_gen u_gen (
    .item   (s1_data_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .burst  (burst)
  );

  assign buf_last = ({1'b0, idx_r} == (cnt_r - 3'd1));
  assign buf_free = !buf_valid_r || (out_ready && buf_last);

  // A command with no bytes never waits for the burst register.
  assign s1_adv   = s1_valid_r && ((burst.count == 3'd0) || buf_free);
  assign load     = s1_adv && (burst.count != 3'd0);
  assign in_ready = !s1_valid_r || s1_adv;

  assign out_valid          = buf_valid_r;
  assign out_data.port_byte = bytes_r[idx_r];
  assign out_data.last_byte = buf_last;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    buf_valid_nxt = buf_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      buf_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (buf_valid_r && out_ready) begin
      if (buf_last) begin
        buf_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      buf_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      buf_valid_r <= buf_valid_nxt;
      idx_r       <= idx_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (load) begin
      bytes_r <= burst.bytes;
      cnt_r   <= burst.count;
    end
  end

`ifndef NO_ASSERTIONS
  // A held burst always has bytes left and the pointer stays inside it.
  a_burst_shape: assert property (@(posedge clk) disable iff (!rst_n)
    buf_valid_r |-> (cnt_r != 3'd0) && ({1'b0, idx_r} < cnt_r))
    else $error("burst register holds an empty or overrun burst");

  // Every effect ends by frame ten, so the frame count never runs past it.
  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.tick <= 4'd10)
    else $error("frame count ran past the longest effect");

  // A command that cannot leave the input register is kept there intact.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_data_r))
    else $error("stalled command lost from the input register");

  // The state moves only when a command is consumed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(state_r))
    else $error("sequencer state changed without a command");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psgseq_pkg::*;

  // The package names only the three function codes that do something; the
  // fourth code is legal on the wire and must be ignored by the block.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // The run is short, so the cycle limit is far above the slowest correct run:
  // every command giving four bytes, each byte waiting out a sparse receiver
  // and every command sitting behind the longest sender gap.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_TICKS = 16;
  localparam int unsigned RANDOM_CMDS  = 100;
  localparam int unsigned REPORT_MAX   = 10;

  // Ways in which the receiver holds off the result channel.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_ALTERNATE,
    RX_SPARSE
  } rx_mode_e;

  // A command waiting to be sent, with a flag that makes the sender hold back
  // until every byte predicted so far has been transferred.
  typedef struct {
    in_t cmd;
    bit  drain_first;
  } pending_cmd_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  sound_effect_psg_sequencer_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // A 2 ns clock: one nanosecond high, one low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Commands still to be sent, and the chip bytes that the accepted commands
  // are predicted to produce, oldest first.
  pending_cmd_t cmd_backlog[$];
  out_t         chip_bytes_due[$];
  logic [7:0]   step_bytes[$];

  // The predictor's own copy of the sequencer state.
  logic [3:0] seq_effect;
  logic [3:0] seq_tick;

  int unsigned cycle_count;
  int unsigned n_cmds_total;
  int unsigned n_accepted;
  int unsigned n_bytes_checked;
  int unsigned n_errors;
  int unsigned n_plays;
  int unsigned n_ticks;
  int unsigned n_inits;
  int unsigned n_unused;

  logic        in_xfer;
  int unsigned burst_left;
  int unsigned gap_left;
  rx_mode_e    rx_mode;
  int unsigned rx_phase_left;

  // ---------------------------------------------------------------------------
  // Predictor. Each helper appends the bytes of one chip write to step_bytes;
  // predict_chip_bytes then queues them with last_byte set on the final one.
  // ---------------------------------------------------------------------------

  // Tone channel 0: latch byte with the low divisor nibble, the upper six
  // divisor bits, then the attenuation (15 minus the volume).
  function automatic void add_tone(int unsigned div, int unsigned vol);
    logic [11:0] d;
    logic [3:0]  att;
    d   = div[11:0];
    att = 4'(15 - vol);
    step_bytes.push_back(CMD_TONE0_DIV | {4'h0, d[3:0]});
    step_bytes.push_back({2'b00, d[9:4]});
    step_bytes.push_back(CMD_TONE0_ATT | {4'h0, att});
  endfunction

  function automatic void add_noise(logic [2:0] ctrl, int unsigned vol);
    logic [3:0] att;
    att = 4'(15 - vol);
    step_bytes.push_back(CMD_NOISE_CTRL | {5'b0, ctrl});
    step_bytes.push_back(CMD_NOISE_ATT | {4'h0, att});
  endfunction

  function automatic void add_mute();
    step_bytes.push_back(CMD_MUTE_CH0);
    step_bytes.push_back(CMD_MUTE_CH1);
    step_bytes.push_back(CMD_MUTE_CH2);
    step_bytes.push_back(CMD_MUTE_NOISE);
  endfunction

  function automatic void predict_chip_bytes(in_t cmd);
    int unsigned t;
    out_t        due;
    step_bytes.delete();
    case (cmd.func)
      FUNC_TICK: begin
        // A tick with nothing playing gives no bytes and leaves the state alone.
        if (seq_effect != EFF_NONE) begin
          seq_tick = seq_tick + 4'd1;
          t = seq_tick;
          case (seq_effect)
            EFF_LASER:       if (t < 6) add_tone(200 + 100 * t, 15 - 2 * t);
            EFF_FOOTSTEP:    if (t == 1) add_noise(3'd6, 6);
            EFF_ROLL:        if (t < 8) add_tone(500 - 40 * t, 12 - t);
            EFF_PICKUP: begin
              if (t < 5) add_tone(180, 14);
              else if (t < 10) add_tone(120, 15);
            end
            EFF_DAMAGE:      if (t < 8) add_noise(3'd7, 15 - t);
            EFF_MENU_MOVE:   if (t < 3) add_tone(250, 12);
            EFF_MENU_SELECT: begin
              if (t < 4) add_tone(180, 14);
              else if (t < 8) add_tone(100, 15);
            end
            EFF_SWITCH:      if (t < 6) add_tone(350 + 40 * t, 12);
            default: ;
          endcase
          // An effect that has run out, or an unknown effect number, mutes every
          // channel and stops.
          if (step_bytes.size() == 0) begin
            seq_effect = EFF_NONE;
            add_mute();
          end
        end
      end
      FUNC_PLAY: begin
        // The number is kept as given, even when no effect carries it.
        seq_effect = cmd.sfx_id;
        seq_tick   = 4'd0;
      end
      FUNC_INIT: begin
        seq_effect = EFF_NONE;
        seq_tick   = 4'd0;
        add_mute();
      end
      default: ;
    endcase
    foreach (step_bytes[i]) begin
      due.port_byte = step_bytes[i];
      due.last_byte = (i == step_bytes.size() - 1);
      chip_bytes_due.push_back(due);
    end
  endfunction

  task automatic flag_error(string msg);
    if (n_errors < REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    n_errors++;
  endtask

  function automatic void add_cmd(logic [1:0] func, logic [3:0] sfx_id, bit drain_first);
    pending_cmd_t p;
    p.cmd.func      = func;
    p.cmd.sfx_id    = sfx_id;
    p.drain_first   = drain_first;
    cmd_backlog.push_back(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. At each falling edge the sender either keeps its current transfer
  // on offer, idles through a gap or a wait, or presents the next command. It
  // works in bursts of random length separated by random gaps; a gap of zero
  // joins two bursts, which gives long stretches with no idling at all.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_xfer) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          in_data  <= in_t'($urandom);
          gap_left <= gap_left - 1;
        end else if (cmd_backlog.size() == 0 ||
                     (cmd_backlog[0].drain_first && chip_bytes_due.size() != 0)) begin
          // Either nothing is left to send, or the next command waits for the
          // result channel to empty completely.
          in_valid <= 1'b0;
          in_data  <= in_t'($urandom);
        end else begin
          in_valid <= 1'b1;
          in_data  <= cmd_backlog[0].cmd;
          cmd_backlog.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It switches between stall patterns at random intervals:
  // always ready, a coin toss, strict alternation, and mostly stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       <= rx_mode_e'($urandom_range(0, 3));
        rx_phase_left <= $urandom_range(8, 40);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_mode)
        RX_OPEN:      out_ready <= 1'b1;
        RX_COIN:      out_ready <= ($urandom_range(0, 1) == 0);
        RX_ALTERNATE: out_ready <= cycle_count[0];
        RX_SPARSE:    out_ready <= ($urandom_range(0, 5) == 0);
        default:      out_ready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge an accepted command is run through the
  // predictor, and an accepted byte is checked against the oldest prediction.
  // A command cannot produce a byte at the edge that accepts it, so the order
  // of the two steps below does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t due;
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_chip_bytes(in_data);
        n_accepted++;
        case (in_data.func)
          FUNC_TICK: n_ticks++;
          FUNC_PLAY: n_plays++;
          FUNC_INIT: n_inits++;
          default:   n_unused++;
        endcase
      end
      if (out_valid && out_ready) begin
        if (chip_bytes_due.size() == 0) begin
          flag_error($sformatf("byte %02h last %0b transferred with nothing expected",
                               out_data.port_byte, out_data.last_byte));
        end else begin
          due = chip_bytes_due.pop_front();
          if (out_data.port_byte !== due.port_byte) begin
            flag_error($sformatf("port_byte expected %02h, got %02h",
                                 due.port_byte, out_data.port_byte));
          end
          if (out_data.last_byte !== due.last_byte) begin
            flag_error($sformatf("last_byte expected %0b, got %0b on byte %02h",
                                 due.last_byte, out_data.last_byte, out_data.port_byte));
          end
          n_bytes_checked++;
        end
      end
    end
  end

  // A run that hangs, whether on the input or the result side, ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached with %0d of %0d commands accepted",
               CYCLE_LIMIT, n_accepted, n_cmds_total);
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n_random;
    int unsigned roll;
    int unsigned run_len;
    bit          mid_drain_done;
    logic [3:0]  effect;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    in_xfer       = 1'b0;
    seq_effect    = EFF_NONE;
    seq_tick      = 4'd0;
    cycle_count   = 0;
    burst_left    = 0;
    gap_left      = 0;
    rx_mode       = RX_OPEN;
    rx_phase_left = 0;
    n_accepted    = 0;
    n_bytes_checked = 0;
    n_errors      = 0;
    n_plays       = 0;
    n_ticks       = 0;
    n_inits       = 0;
    n_unused      = 0;
    mid_drain_done = 1'b0;

    // Directed part. The sfx_id of ticks and inits carries junk on purpose,
    // since the block must ignore it.
    add_cmd(FUNC_INIT,   4'd15,           1'b0);  // mute from reset
    add_cmd(FUNC_TICK,   4'd15,           1'b0);  // tick with nothing playing
    add_cmd(FUNC_UNUSED, 4'd15,           1'b0);  // unused code, ignored
    add_cmd(FUNC_UNUSED, 4'd0,            1'b0);
    add_cmd(FUNC_PLAY,   4'd15,           1'b0);  // highest unknown effect
    add_cmd(FUNC_TICK,   4'd0,            1'b0);  // unknown effect mutes and stops
    add_cmd(FUNC_TICK,   4'd0,            1'b0);  // now nothing plays
    add_cmd(FUNC_PLAY,   EFF_LASER,       1'b0);
    add_cmd(FUNC_TICK,   4'd0,            1'b0);
    add_cmd(FUNC_TICK,   4'd9,            1'b0);
    add_cmd(FUNC_PLAY,   EFF_NONE,        1'b0);  // play of no effect stops silently
    add_cmd(FUNC_TICK,   4'd0,            1'b0);
    add_cmd(FUNC_PLAY,   EFF_DAMAGE,      1'b1);  // sent only once all bytes are out
    add_cmd(FUNC_TICK,   4'd15,           1'b0);
    add_cmd(FUNC_INIT,   4'd0,            1'b0);  // init while an effect runs
    add_cmd(FUNC_TICK,   4'd0,            1'b0);
    add_cmd(FUNC_PLAY,   EFF_FOOTSTEP,    1'b0);
    add_cmd(FUNC_TICK,   4'd0,            1'b0);  // the single noise write
    add_cmd(FUNC_TICK,   4'd0,            1'b0);  // footstep over: mute
    add_cmd(FUNC_PLAY,   4'd9,            1'b0);  // lowest unknown effect
    add_cmd(FUNC_TICK,   4'd0,            1'b0);

    // Random part. Most of it is a play followed by one to eleven ticks; the
    // longest runs carry every effect to its end and the mute that follows,
    // shorter ones may be cut short. The rest is loose commands of any code,
    // which break sequences up with inits, stray plays and unused codes.
    n_random = 0;
    while (n_random < RANDOM_CMDS) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        effect = (roll == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
        add_cmd(FUNC_PLAY, effect, n_random >= RANDOM_CMDS / 2 && !mid_drain_done);
        if (n_random >= RANDOM_CMDS / 2) begin
          mid_drain_done = 1'b1;
        end
        run_len = $urandom_range(1, 11);
        repeat (run_len) add_cmd(FUNC_TICK, 4'($urandom_range(0, 15)), 1'b0);
        n_random += run_len + 1;
      end else begin
        add_cmd(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b0);
        n_random++;
      end
    end
    n_cmds_total = cmd_backlog.size();

    // Synchronous reset, released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Waiting on falling edges reads the counters and the queue once the
    // rising-edge updates have settled.
    while (n_accepted != n_cmds_total) @(negedge clk);
    while (chip_bytes_due.size() != 0) @(negedge clk);
    // Any stray byte still in the pipeline shows up before the run ends.
    repeat (SETTLE_TICKS) @(negedge clk);

    $display("Covered %0d commands: %0d plays, %0d ticks, %0d inits, %0d unused codes.",
             n_accepted, n_plays, n_ticks, n_inits, n_unused);
    $display("Checked %0d chip command bytes, %0d mismatches.",
             n_bytes_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sound_effect_psg_sequencer_top.f =====
rtl/core/psgseq_pkg.sv
rtl/core/psgseq_gen.sv
rtl/core/sound_effect_psg_sequencer_top.sv
tb/sv/tb_top.sv
